// ----- sv/dpdf_pkg.sv -----
package dpdf_pkg;

   localparam int NUMBER_WIDTH = 16;
   localparam int COUNT_WIDTH  = 3;
   localparam int STEP_WIDTH   = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

   localparam logic [COUNT_WIDTH-1:0]  MAX_DIVISORS   = COUNT_WIDTH'(6);
   localparam logic [NUMBER_WIDTH-1:0] SMALLEST_PRIME = NUMBER_WIDTH'(2);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_COMPARE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT_DIV,
      ST_NEXT,
      ST_LEFTOVER,
      ST_SUMMARY
   } state_type;

   typedef struct packed {
      logic                    start;
      logic [NUMBER_WIDTH-1:0] dividend;
      logic [NUMBER_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic [NUMBER_WIDTH-1:0] quotient;
      logic [NUMBER_WIDTH-1:0] remainder;
   } div_rsp_type;

endpackage

// ----- sv/distinct_prime_divisor_finder.sv -----
// Each trial candidate p takes a square, a compare and one pass of the shared restoring
// divider, and every extra division strips a found factor; candidates run up to the
// square root of the shrinking number.
// Throughput: one item at a time; req_stall is high from acceptance until the summary is loaded.
// Reset: synchronous, active high; clears the sequencer, the divider and the result valid.
module distinct_prime_divisor_finder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dpdf_pkg::NUMBER_WIDTH-1:0]     req_number,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [dpdf_pkg::NUMBER_WIDTH-1:0]     rsp_divisor,
   output logic [dpdf_pkg::COUNT_WIDTH-1:0]      rsp_divisor_count,
   output logic                                  rsp_number_is_prime,
   output logic                                  rsp_is_summary,
   output logic                                  rsp_last
);
   import dpdf_pkg::*;

   state_type state_ff, state_in;

   // Working registers of the trial division.
   logic [NUMBER_WIDTH-1:0]   number_ff, number_in;
   logic [NUMBER_WIDTH-1:0]   rest_ff, rest_in;
   logic [NUMBER_WIDTH-1:0]   cand_ff, cand_in;
   logic [2*NUMBER_WIDTH-1:0] square_ff, square_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      found_ff, found_in;

   // Output register; it frees the sequencer from the consumer.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_WIDTH-1:0]   rsp_divisor_ff, rsp_divisor_in;
   logic [COUNT_WIDTH-1:0]    rsp_count_ff, rsp_count_in;
   logic                      rsp_prime_ff, rsp_prime_in;
   logic                      rsp_summary_ff, rsp_summary_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic accept;
   logic slot_free;
   logic has_room;
   logic leftover_ok;

   dpdf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign has_room    = (count_ff < MAX_DIVISORS);
   // A leftover factor counts only when it is not the number itself.
   assign leftover_ok = (rest_ff > NUMBER_WIDTH'(1)) && (rest_ff < number_ff) && has_room;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SQUARE;
         end
         ST_SQUARE:    state_in = ST_COMPARE;
         ST_COMPARE: begin
            if (square_ff <= {{NUMBER_WIDTH{1'b0}}, rest_ff}) state_in = ST_DIV_START;
            else state_in = ST_LEFTOVER;
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != '0) state_in = ST_NEXT;
               else if (!found_ff && has_room) state_in = ST_EMIT_DIV;
               else state_in = ST_DIV_START;
            end
         end
         ST_EMIT_DIV: begin
            if (slot_free) state_in = ST_DIV_START;
         end
         ST_NEXT:      state_in = ST_SQUARE;
         ST_LEFTOVER: begin
            if (!leftover_ok || slot_free) state_in = ST_SUMMARY;
         end
         ST_SUMMARY: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      number_in        = number_ff;
      rest_in          = rest_ff;
      cand_in          = cand_ff;
      square_in        = square_ff;
      count_in         = count_ff;
      found_in         = found_ff;
      div_req.start    = 1'b0;
      div_req.dividend = rest_ff;
      div_req.divisor  = cand_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_divisor_in   = rsp_divisor_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_prime_in     = rsp_prime_ff;
      rsp_summary_in   = rsp_summary_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               number_in = req_number;
               rest_in   = req_number;
               cand_in   = SMALLEST_PRIME;
               count_in  = '0;
               found_in  = 1'b0;
            end
         end
         ST_SQUARE: begin
            square_in = {{NUMBER_WIDTH{1'b0}}, cand_ff} * {{NUMBER_WIDTH{1'b0}}, cand_ff};
         end
         ST_DIV_START: begin
            div_req.start = 1'b1;
         end
         ST_DIV_WAIT: begin
            // Each exact division strips one factor, the first one included, so keep its quotient.
            if (div_rsp.done && div_rsp.remainder == '0) begin
               rest_in  = div_rsp.quotient;
               found_in = 1'b1;
            end
         end
         ST_EMIT_DIV: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_divisor_in = cand_ff;
               rsp_count_in   = '0;
               rsp_prime_in   = 1'b0;
               rsp_summary_in = 1'b0;
               count_in       = count_ff + 1'b1;
            end
         end
         ST_NEXT: begin
            cand_in  = cand_ff + 1'b1;
            found_in = 1'b0;
         end
         ST_LEFTOVER: begin
            if (leftover_ok && slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_divisor_in = rest_ff;
               rsp_count_in   = '0;
               rsp_prime_in   = 1'b0;
               rsp_summary_in = 1'b0;
               count_in       = count_ff + 1'b1;
            end
         end
         ST_SUMMARY: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_divisor_in = '0;
               rsp_count_in   = count_ff;
               rsp_prime_in   = (count_ff == '0);
               rsp_summary_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      number_ff      <= number_in;
      rest_ff        <= rest_in;
      cand_ff        <= cand_in;
      square_ff      <= square_in;
      count_ff       <= count_in;
      found_ff       <= found_in;
      rsp_divisor_ff <= rsp_divisor_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_prime_ff   <= rsp_prime_in;
      rsp_summary_ff <= rsp_summary_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_divisor         = rsp_divisor_ff;
   assign rsp_divisor_count   = rsp_count_ff;
   assign rsp_number_is_prime = rsp_prime_ff;
   assign rsp_is_summary      = rsp_summary_ff;
   assign rsp_last            = rsp_summary_ff;

endmodule

// ----- sv/dpdf_divider.sv -----
module dpdf_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  dpdf_pkg::div_req_type div_req,
   output dpdf_pkg::div_rsp_type div_rsp
);
   import dpdf_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] quo_ff, quo_in;
   logic [NUMBER_WIDTH-1:0] den_ff, den_in;
   logic [NUMBER_WIDTH:0]   shifted;
   logic [NUMBER_WIDTH:0]   trial;

   // One quotient bit per cycle, restoring style; the dividend shifts out of quo_ff.
   always_comb begin
      shifted = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
      trial   = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_WIDTH'(NUMBER_WIDTH - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[NUMBER_WIDTH]) begin
            rem_in = trial[NUMBER_WIDTH-1:0];
            quo_in = {quo_ff[NUMBER_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[NUMBER_WIDTH-1:0];
            quo_in = {quo_ff[NUMBER_WIDTH-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
